FILE: rtl/mipmap_chain_box_filter_unit_assert.svh
// ----------------------------------------------------------------------------
// mipmap_chain_box_filter_unit_assert.svh
// Assertion macros used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef MIPMAP_CHAIN_BOX_FILTER_UNIT_ASSERT_SVH
`define MIPMAP_CHAIN_BOX_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MCBF_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mcbf same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MCBF_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcbf next-cycle check failed");

`endif

FILE: rtl/mcbf_pkg.sv
// ----------------------------------------------------------------------------
// mcbf_pkg
// Shared constants and types of the mipmap chain box filter.
// ----------------------------------------------------------------------------
package mcbf_pkg;

  localparam int CFG_W      = 11;  // width of the config data port
  localparam int CFG_IDX_W  = 2;
  localparam int PIX_W      = 32;
  localparam int POS_W      = 10;  // column/row counter per level
  localparam int OUT_POS_W  = 9;
  localparam int LVL_W      = 4;
  localparam int NUM_LEVELS = 11;
  localparam int LVL_STEPS  = 10;  // levels an input can walk through
  localparam int LANE_W     = 9;
  localparam int PAIR_W     = 36;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GEN_ENABLE   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_CALC,
    ST_FINISH
  } state_t;

  // Strobes from the sequencer to the datapath.
  typedef struct packed {
    logic start;      // accept input, begin walk
    logic cnt_upd;    // advance level counters
    logic ram_re;
    logic left_we;
    logic ram_we;
    logic emit;       // new level result into pending slot
    logic push;       // pending slot into output register
    logic push_last;
  } ctrl_t;

endpackage

FILE: rtl/mcbf_pair_ram.sv
// ----------------------------------------------------------------------------
// mcbf_pair_ram
// Pair-sum store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mcbf_pair_ram #(
  parameter int DEPTH = mcbf_pkg::DEF_MAX_WIDTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [mcbf_pkg::PAIR_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [mcbf_pkg::PAIR_W-1:0] rdata
);

  logic [mcbf_pkg::PAIR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/mcbf_avg.sv
// ----------------------------------------------------------------------------
// mcbf_avg
// Per-channel 2x2 box filter: horizontal pair sum, vertical sum, divide by 4.
// ----------------------------------------------------------------------------
module mcbf_avg (
  input  logic [mcbf_pkg::PIX_W-1:0]  left_pix,
  input  logic [mcbf_pkg::PIX_W-1:0]  cur_pix,
  input  logic [mcbf_pkg::PAIR_W-1:0] pair_in,
  input  logic                        use_left,
  input  logic                        use_pair,
  output logic [mcbf_pkg::PAIR_W-1:0] hsum_out,
  output logic [mcbf_pkg::PIX_W-1:0]  res
);

  always_comb begin
    logic [8:0] h;
    logic [9:0] t;
    hsum_out = '0;
    res      = '0;
    for (int k = 0; k < 4; k++) begin
      if (use_left) begin
        h = {1'b0, left_pix[8*k +: 8]} + {1'b0, cur_pix[8*k +: 8]};
      end else begin
        h = {cur_pix[8*k +: 8], 1'b0};
      end
      if (use_pair) begin
        t = {1'b0, pair_in[9*k +: 9]} + {1'b0, h};
      end else begin
        t = {h, 1'b0};
      end
      hsum_out[9*k +: 9] = h;
      res[8*k +: 8]      = t[9:2];
    end
  end

endmodule

FILE: rtl/mipmap_chain_box_filter_unit.sv
// ----------------------------------------------------------------------------
// mipmap_chain_box_filter_unit
// Streams base RGBA8 pixels in raster order and emits the full mip chain,
// each level a truncated 2x2 box average of the level above.
// ----------------------------------------------------------------------------
// Usage: program image_width, image_height and generate_enable while idle;
// any write to these restarts the image at pixel (0,0). With generation off,
// or a size that is not a power of two within MAX_WIDTH x MAX_HEIGHT, input
// transactions are taken and dropped. Sequence: an input walks the level
// chain one level at a time on a shared filter. It is accepted in IDLE;
// each emitted level takes LOOK (counter lookup and pair-sum memory read),
// then CALC (filter). The level that stops the walk takes LOOK alone to keep
// an even-column pixel or to hit the 1x1 level, or LOOK and CALC to store an
// even-row pair sum; FINISH then ends the walk. Results of one input leave in
// rising level order; the last carries out_last_of_run. One result is held
// pending until the next level decides whether it is the last; the walk
// stalls only while both the pending slot and the output register are full.
// The pair-sum memory needs no clearing pass: every entry is written on an
// even row before the odd row reads it.
// ----------------------------------------------------------------------------
module mipmap_chain_box_filter_unit #(
  parameter int MAX_WIDTH  = mcbf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mcbf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // config write port
  input  logic                           cfg_we,
  input  logic [mcbf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mcbf_pkg::CFG_W-1:0]     cfg_data,
  // base pixel channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [mcbf_pkg::PIX_W-1:0]     in_pixel,
  // mip result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mcbf_pkg::LVL_W-1:0]     out_level,
  output logic [mcbf_pkg::OUT_POS_W-1:0] out_x,
  output logic [mcbf_pkg::OUT_POS_W-1:0] out_y,
  output logic [mcbf_pkg::PIX_W-1:0]     out_mip_pixel,
  output logic                           out_last_of_run,
  output logic                           out_chain_done
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int IW = ((AW > mcbf_pkg::POS_W) ? AW : mcbf_pkg::POS_W) + 2;
  localparam int LW = 14;  // holds the largest size limit for compares

  // ---- configuration ----
  logic [mcbf_pkg::CFG_W-1:0] width_r, height_r;
  logic                       gen_en_r;
  logic                       cfg_hit;

  assign cfg_hit = cfg_we && (cfg_index == mcbf_pkg::REG_IMAGE_WIDTH ||
                              cfg_index == mcbf_pkg::REG_IMAGE_HEIGHT ||
                              cfg_index == mcbf_pkg::REG_GEN_ENABLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= mcbf_pkg::CFG_W'(1);
      height_r <= mcbf_pkg::CFG_W'(1);
      gen_en_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        mcbf_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_data;
        mcbf_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_data;
        mcbf_pkg::REG_GEN_ENABLE:   gen_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Generation on, power of two, nonzero, within the limit.
  logic usable;
  assign usable = gen_en_r &&
                  (width_r != '0) && ((width_r & (width_r - 1'b1)) == '0) &&
                  (LW'(width_r) <= LW'(MAX_WIDTH)) &&
                  (height_r != '0) && ((height_r & (height_r - 1'b1)) == '0) &&
                  (LW'(height_r) <= LW'(MAX_HEIGHT));

  // ---- sequencer ----
  mcbf_pkg::state_t state_r, state_nxt;
  mcbf_pkg::ctrl_t  ctl;

  logic [mcbf_pkg::LVL_W-1:0] s_r;
  logic                       pend_valid_r;
  logic                       out_free;

  // level lookup (LOOK)
  logic [mcbf_pkg::POS_W-1:0] col_r [mcbf_pkg::NUM_LEVELS];
  logic [mcbf_pkg::POS_W-1:0] row_r [mcbf_pkg::NUM_LEVELS];
  logic [mcbf_pkg::CFG_W-1:0] wsh, hsh, ws, hs;
  logic [mcbf_pkg::POS_W-1:0] c_cur, r_cur;
  logic                       lvl_end, keep_left;

  assign wsh     = width_r >> s_r;
  assign hsh     = height_r >> s_r;
  assign ws      = (wsh == '0) ? mcbf_pkg::CFG_W'(1) : wsh;
  assign hs      = (hsh == '0) ? mcbf_pkg::CFG_W'(1) : hsh;
  assign c_cur   = col_r[s_r];
  assign r_cur   = row_r[s_r];
  assign lvl_end   = (ws == mcbf_pkg::CFG_W'(1)) && (hs == mcbf_pkg::CFG_W'(1));
  assign keep_left = (ws > mcbf_pkg::CFG_W'(1)) && !c_cur[0];

  // store_pair: even row of a level with height above 1
  logic store_pair_r;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mcbf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mcbf_pkg::ST_IDLE: begin
        if (in_valid && usable) begin
          state_nxt = mcbf_pkg::ST_LOOK;
        end
      end
      mcbf_pkg::ST_LOOK: begin
        if (lvl_end || keep_left) begin
          state_nxt = mcbf_pkg::ST_FINISH;
        end else begin
          state_nxt = mcbf_pkg::ST_CALC;
        end
      end
      mcbf_pkg::ST_CALC: begin
        if (store_pair_r) begin
          state_nxt = mcbf_pkg::ST_FINISH;
        end else if (!pend_valid_r || out_free) begin
          if (s_r == mcbf_pkg::LVL_W'(mcbf_pkg::LVL_STEPS - 1)) begin
            state_nxt = mcbf_pkg::ST_FINISH;
          end else begin
            state_nxt = mcbf_pkg::ST_LOOK;
          end
        end
      end
      mcbf_pkg::ST_FINISH: begin
        if (!pend_valid_r || out_free) begin
          state_nxt = mcbf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mcbf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    case (state_r)
      mcbf_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        ctl.start = in_valid && usable;
      end
      mcbf_pkg::ST_LOOK: begin
        ctl.cnt_upd = 1'b1;
        ctl.left_we = !lvl_end && keep_left;
        ctl.ram_re  = !lvl_end && !keep_left;
      end
      mcbf_pkg::ST_CALC: begin
        if (store_pair_r) begin
          ctl.ram_we = 1'b1;
        end else if (!pend_valid_r || out_free) begin
          ctl.emit = 1'b1;
          ctl.push = pend_valid_r;
        end
      end
      mcbf_pkg::ST_FINISH: begin
        ctl.push      = pend_valid_r && out_free;
        ctl.push_last = 1'b1;
      end
      default: ;
    endcase
  end

  // ---- datapath ----
  logic [mcbf_pkg::PIX_W-1:0]  p_r;
  logic [mcbf_pkg::PIX_W-1:0]  left_r [mcbf_pkg::LVL_STEPS];
  logic [mcbf_pkg::POS_W-1:0]  c_r, r_r;
  logic                        use_left_r, use_pair_r, chain_r;
  logic [AW-1:0]               idx, idx_r;
  logic [IW-1:0]               idx_sum;
  logic [mcbf_pkg::PAIR_W-1:0] pair_rd, hsum;
  logic [mcbf_pkg::PIX_W-1:0]  res;

  // Row slot of level s starts at MAX_WIDTH - (MAX_WIDTH >> s), folded once.
  always_comb begin
    idx_sum = IW'(MAX_WIDTH) - (IW'(MAX_WIDTH) >> s_r) + IW'(c_cur >> 1);
    if (idx_sum >= IW'(MAX_WIDTH)) begin
      idx_sum = idx_sum - IW'(MAX_WIDTH);
    end
    idx = idx_sum[AW-1:0];
  end

  logic [mcbf_pkg::LVL_W-1:0] left_sel;
  assign left_sel = (s_r < mcbf_pkg::LVL_W'(mcbf_pkg::LVL_STEPS)) ? s_r : '0;

  mcbf_pair_ram #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.ram_we),
    .waddr (idx_r),
    .wdata (hsum),
    .re    (ctl.ram_re),
    .raddr (idx),
    .rdata (pair_rd)
  );

  mcbf_avg u_avg (
    .left_pix (left_r[left_sel]),
    .cur_pix  (p_r),
    .pair_in  (pair_rd),
    .use_left (use_left_r),
    .use_pair (use_pair_r),
    .hsum_out (hsum),
    .res      (res)
  );

  // level position counters
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      for (int i = 0; i < mcbf_pkg::NUM_LEVELS; i++) begin
        col_r[i] <= '0;
        row_r[i] <= '0;
      end
    end else if (ctl.cnt_upd) begin
      if ((mcbf_pkg::CFG_W'(c_cur) + 1'b1) >= ws) begin
        col_r[s_r] <= '0;
        if ((mcbf_pkg::CFG_W'(r_cur) + 1'b1) >= hs) begin
          row_r[s_r] <= '0;
        end else begin
          row_r[s_r] <= r_cur + 1'b1;
        end
      end else begin
        col_r[s_r] <= c_cur + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.left_we) begin
      left_r[left_sel] <= p_r;
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      p_r <= in_pixel;
    end else if (ctl.emit) begin
      p_r <= res;
    end
    if (ctl.cnt_upd) begin
      c_r          <= c_cur;
      r_r          <= r_cur;
      idx_r        <= idx;
      use_left_r   <= ws > mcbf_pkg::CFG_W'(1);
      use_pair_r   <= hs > mcbf_pkg::CFG_W'(1);
      store_pair_r <= (hs > mcbf_pkg::CFG_W'(1)) && !r_cur[0];
      chain_r      <= (ws <= mcbf_pkg::CFG_W'(2)) && (hs <= mcbf_pkg::CFG_W'(2));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= '0;
    end else if (ctl.start) begin
      s_r <= '0;
    end else if (ctl.emit) begin
      s_r <= s_r + 1'b1;
    end
  end

  // pending result: its last flag is known once the next level is decided
  logic [mcbf_pkg::LVL_W-1:0]     pend_level_r;
  logic [mcbf_pkg::OUT_POS_W-1:0] pend_x_r, pend_y_r;
  logic [mcbf_pkg::PIX_W-1:0]     pend_pix_r;
  logic                           pend_chain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (ctl.emit) begin
      pend_valid_r <= 1'b1;
    end else if (ctl.push) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      pend_level_r <= s_r + 1'b1;
      pend_x_r     <= mcbf_pkg::OUT_POS_W'(c_r >> 1);
      pend_y_r     <= mcbf_pkg::OUT_POS_W'(r_r >> 1);
      pend_pix_r   <= res;
      pend_chain_r <= chain_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (ctl.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      out_level       <= pend_level_r;
      out_x           <= pend_x_r;
      out_y           <= pend_y_r;
      out_mip_pixel   <= pend_pix_r;
      out_last_of_run <= ctl.push_last;
      out_chain_done  <= pend_chain_r;
    end
  end

endmodule

FILE: rtl/mcbf_checker.sv
// ----------------------------------------------------------------------------
// mcbf_checker
// Port-level checks of the mipmap chain box filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "mipmap_chain_box_filter_unit_assert.svh"

module mcbf_port_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [mcbf_pkg::LVL_W-1:0]     out_level,
  input logic [mcbf_pkg::OUT_POS_W-1:0] out_x,
  input logic [mcbf_pkg::OUT_POS_W-1:0] out_y,
  input logic [mcbf_pkg::PIX_W-1:0]     out_mip_pixel,
  input logic                           out_last_of_run,
  input logic                           out_chain_done
);

  // stalled result transaction holds
  `MCBF_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_mip_pixel) && $stable(out_level))

  // a 1x1 level result is always the last of its run
  `MCBF_IMPLY(a_chain_last, out_valid && out_chain_done, out_last_of_run)

  // the 1x1 level has a single pixel at the origin
  `MCBF_IMPLY(a_chain_origin, out_valid && out_chain_done, out_x == '0 && out_y == '0)

  // level index stays within the chain
  `MCBF_IMPLY(a_level_range, out_valid, out_level >= 4'd1 && out_level <= 4'd10)

endmodule

bind mipmap_chain_box_filter_unit mcbf_port_checker u_mcbf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_level       (out_level),
  .out_x           (out_x),
  .out_y           (out_y),
  .out_mip_pixel   (out_mip_pixel),
  .out_last_of_run (out_last_of_run),
  .out_chain_done  (out_chain_done)
);

FILE: tb/mcbf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcbf_checker
// Watches the config port and both channels of the mip chain filter, keeps
// its own model of the level walk and compares each result transaction.
// ----------------------------------------------------------------------------
module mcbf_checker #(
  parameter int MAX_W = mcbf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_H = mcbf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mcbf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mcbf_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [mcbf_pkg::PIX_W-1:0]     in_pixel,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [mcbf_pkg::LVL_W-1:0]     out_level,
  input  logic [mcbf_pkg::OUT_POS_W-1:0] out_x,
  input  logic [mcbf_pkg::OUT_POS_W-1:0] out_y,
  input  logic [mcbf_pkg::PIX_W-1:0]     out_mip_pixel,
  input  logic                           out_last_of_run,
  input  logic                           out_chain_done,
  output int                             fail_count,
  output int                             pending_count,
  output int                             checked_count
);

  typedef struct {
    logic [mcbf_pkg::LVL_W-1:0]     lvl;
    logic [mcbf_pkg::OUT_POS_W-1:0] x;
    logic [mcbf_pkg::OUT_POS_W-1:0] y;
    logic [mcbf_pkg::PIX_W-1:0]     pix;
    logic                           last;
    logic                           done;
  } mip_result_t;

  mip_result_t mip_q[$];

  logic [mcbf_pkg::CFG_W-1:0]  img_w, img_h;
  logic                        gen_en;
  logic [mcbf_pkg::PAIR_W-1:0] row_pairs [MAX_W];
  logic [mcbf_pkg::PIX_W-1:0]  even_pix  [mcbf_pkg::LVL_STEPS];
  int unsigned                 col_pos   [mcbf_pkg::NUM_LEVELS];
  int unsigned                 row_pos   [mcbf_pkg::NUM_LEVELS];

  function automatic bit pow2_ok(int unsigned v, int unsigned lim);
    return v != 0 && (v & (v - 1)) == 0 && v <= lim;
  endfunction

  // Walk one base pixel down the chain, queueing every level it completes.
  task automatic walk_chain(input logic [mcbf_pkg::PIX_W-1:0] px);
    int unsigned s, ws, hs, c, r, idx, nw, nh, first;
    int unsigned hsum[4], tot[4];
    logic [mcbf_pkg::PIX_W-1:0] p, res;
    logic [mcbf_pkg::PAIR_W-1:0] packed_sum;
    mip_result_t m;
    p = px;
    first = mip_q.size();
    if (!gen_en || !pow2_ok(img_w, MAX_W) || !pow2_ok(img_h, MAX_H)) return;
    for (s = 0; s < mcbf_pkg::LVL_STEPS; s++) begin
      ws = img_w >> s; hs = img_h >> s;
      if (ws == 0) ws = 1;
      if (hs == 0) hs = 1;
      c = col_pos[s]; r = row_pos[s];
      if (c + 1 >= ws) begin
        col_pos[s] = 0;
        row_pos[s] = (r + 1 >= hs) ? 0 : r + 1;
      end else begin
        col_pos[s] = c + 1;
      end
      if (ws == 1 && hs == 1) break;
      if (ws > 1) begin
        if (c[0] == 1'b0) begin
          even_pix[s] = p;
          break;
        end
        for (int k = 0; k < 4; k++) hsum[k] = even_pix[s][8*k +: 8] + p[8*k +: 8];
      end else begin
        for (int k = 0; k < 4; k++) hsum[k] = 2 * p[8*k +: 8];
      end
      if (hs > 1) begin
        idx = (MAX_W - (MAX_W >> s) + (c >> 1)) % MAX_W;
        if (r[0] == 1'b0) begin
          for (int k = 0; k < 4; k++) packed_sum[9*k +: 9] = hsum[k][8:0];
          row_pairs[idx] = packed_sum;
          break;
        end
        for (int k = 0; k < 4; k++) tot[k] = row_pairs[idx][9*k +: 9] + hsum[k];
      end else begin
        for (int k = 0; k < 4; k++) tot[k] = 2 * hsum[k];
      end
      for (int k = 0; k < 4; k++) res[8*k +: 8] = 8'(tot[k] >> 2);
      nw = ws >> 1; if (nw == 0) nw = 1;
      nh = hs >> 1; if (nh == 0) nh = 1;
      m.lvl = mcbf_pkg::LVL_W'(s + 1);
      m.x = mcbf_pkg::OUT_POS_W'(c >> 1);
      m.y = mcbf_pkg::OUT_POS_W'(r >> 1);
      m.pix = res;
      m.last = 1'b0; m.done = (nw == 1 && nh == 1);
      mip_q.push_back(m);
      p = res;
    end
    if (mip_q.size() > first) mip_q[mip_q.size() - 1].last = 1'b1;
  endtask

  task automatic fld(input string name, input longint e, input longint a);
    if (e != a) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0; checked_count = 0; pending_count = 0;
  end

  always @(posedge clk) begin
    mip_result_t m;
    if (!rst_n) begin
      img_w = 1; img_h = 1; gen_en = 1'b0;
      for (int i = 0; i < mcbf_pkg::NUM_LEVELS; i++) begin
        col_pos[i] = 0; row_pos[i] = 0;
      end
      mip_q.delete();
    end else begin
      if (cfg_we && cfg_index <= mcbf_pkg::REG_GEN_ENABLE) begin
        case (cfg_index)
          mcbf_pkg::REG_IMAGE_WIDTH:  img_w = cfg_data;
          mcbf_pkg::REG_IMAGE_HEIGHT: img_h = cfg_data;
          mcbf_pkg::REG_GEN_ENABLE:   gen_en = cfg_data[0];
          default: ;
        endcase
        for (int i = 0; i < mcbf_pkg::NUM_LEVELS; i++) begin
          col_pos[i] = 0; row_pos[i] = 0;
        end
      end
      if (in_valid && in_ready) walk_chain(in_pixel);
      if (out_valid && out_ready) begin
        checked_count++;
        if (mip_q.size() == 0) begin
          $error("unexpected result transaction: level %0d x %0d y %0d",
                 out_level, out_x, out_y);
          fail_count++;
        end else begin
          m = mip_q.pop_front();
          fld("level", m.lvl, out_level);
          fld("out_x", m.x, out_x);
          fld("out_y", m.y, out_y);
          fld("mip_pixel", m.pix, out_mip_pixel);
          fld("last_of_run", m.last, out_last_of_run);
          fld("chain_done", m.done, out_chain_done);
        end
      end
    end
    pending_count = mip_q.size();
  end

endmodule

FILE: tb/tb_mipmap_chain_box_filter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mipmap_chain_box_filter_unit
// Streams base images of assorted sizes through the mip chain filter under
// bursty input and a stalling receiver; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_mipmap_chain_box_filter_unit;

  localparam int CYCLE_LIMIT = 50000;
  localparam int DRAIN_GAP   = 40;   // well above the length of a ten-level walk

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [mcbf_pkg::CFG_IDX_W-1:0] cfg_index = mcbf_pkg::REG_IMAGE_WIDTH;
  logic [mcbf_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [mcbf_pkg::PIX_W-1:0]     in_pixel = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [mcbf_pkg::LVL_W-1:0]     out_level;
  logic [mcbf_pkg::OUT_POS_W-1:0] out_x, out_y;
  logic [mcbf_pkg::PIX_W-1:0]     out_mip_pixel;
  logic                           out_last_of_run, out_chain_done;

  int fail_count, pending_count, checked_count;
  int cycle_count = 0;
  int sent_count = 0;
  int setting_count = 0;
  int burst_left = 0;
  logic hold_req = 1'b0;  // asks the receiver for one long hold-off

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mipmap_chain_box_filter_unit dut (.*);

  mcbf_checker chk (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_pixel,
    .out_valid, .out_ready, .out_level, .out_x, .out_y, .out_mip_pixel,
    .out_last_of_run, .out_chain_done,
    .fail_count, .pending_count, .checked_count
  );

  // Receiver: rotates through four stall patterns; a hold
  // request drops ready for a long counted stretch so the block backs up.
  int hold_left = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (hold_req && hold_left == 0) begin
      hold_left <= 400;
      out_ready <= 1'b0;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (hold_left == 1) hold_left <= -1;  // one hold per request flag
      case ((cycle_count >> 8) % 4)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 9) < 3);
        default: out_ready <= (cycle_count % 3 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Single register write; cfg_we drops on the following edge.
  task automatic write_reg(input logic [mcbf_pkg::CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= mcbf_pkg::CFG_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one pixel; valid stays up into the next transaction unless a gap
  // between bursts is drawn.
  task automatic send_pixel(input logic [mcbf_pkg::PIX_W-1:0] px);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_pixel <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  // Close the stream and let every result drain before config changes.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic set_image(input int w, input int h, input int en);
    write_reg(mcbf_pkg::REG_IMAGE_WIDTH, w);
    write_reg(mcbf_pkg::REG_IMAGE_HEIGHT, h);
    write_reg(mcbf_pkg::REG_GEN_ENABLE, en);
    setting_count++;
  endtask

  logic [mcbf_pkg::PIX_W-1:0] corner_pix [8] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                                 32'h8080_8080, 32'h0101_0101,
                                                 32'hAA55_AA55, 32'h55AA_55AA,
                                                 32'h0302_0100, 32'hFFFE_FDFC};

  initial begin
    int w, h, n, sel;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: generation off, pixels are dropped.
    for (int i = 0; i < 4; i++) send_pixel(corner_pix[i]);
    drain();

    // 4x4 with extreme and rounding-sensitive pixels, one full image and four more.
    set_image(4, 4, 1);
    for (int i = 0; i < 16; i++) send_pixel(corner_pix[i % 8]);
    for (int i = 0; i < 4; i++) send_pixel(32'h0303_0303 * (i & 1));
    drain();

    // 1x1 base, non power of two, zero and top-of-range sizes emit nothing.
    set_image(1, 1, 1);
    send_pixel(32'hFFFF_FFFF);
    drain();
    set_image(3, 4, 1);
    send_pixel(32'h1234_5678);
    drain();
    set_image(0, 2047, 1);
    send_pixel(32'h8765_4321);
    drain();
    // Out-of-list index is ignored.
    write_reg(mcbf_pkg::CFG_IDX_W'(mcbf_pkg::REG_GEN_ENABLE + 1), 11'h7FF);

    // Long row and tall column: the last pixel walks six and four levels.
    set_image(64, 1, 1);
    for (int i = 0; i < 64; i++) send_pixel($urandom);
    drain();
    set_image(1, 16, 1);
    for (int i = 0; i < 16; i++) send_pixel($urandom);
    drain();

    // Largest usable size: start of the first row only.
    set_image(1024, 1024, 1);
    for (int i = 0; i < 8; i++) send_pixel($urandom);
    drain();

    // Random small images; the first one also gets the long receiver hold.
    for (int ph = 0; ph < 3; ph++) begin
      w = 1 << $urandom_range(0, 2);
      h = 1 << $urandom_range(0, 2);
      sel = $urandom_range(0, 9);
      if (ph == 0) begin
        w = 4; h = 4; sel = 2;
      end
      if (sel == 0) set_image(w, h, 0);
      else if (sel == 1) set_image(w + 5, h, 1);
      else set_image(w, h, 1);
      n = (w * h < 8) ? 8 : w * h;
      if (ph != 0 && $urandom_range(0, 3) == 0) n = $urandom_range(1, n);
      if (ph == 0) hold_req <= 1'b1;
      for (int i = 0; i < n; i++) send_pixel($urandom);
      hold_req <= 1'b0;
      drain();
    end

    $display("Sent %0d pixel transactions over %0d image settings.", sent_count,
             setting_count);
    $display("Compared %0d mip result transactions.", checked_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
